>>> rtl/stack_vm_integer_execute_defines.svh
// Assertion macros shared by the RTL of the stack machine execute block
`ifndef STACK_VM_INTEGER_EXECUTE_DEFINES_SVH
`define STACK_VM_INTEGER_EXECUTE_DEFINES_SVH
// Implication checked on every edge outside reset
`define SVIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define SVIE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/svie_pkg.sv
// ---------------------------------------------------------------------------
// svie_pkg
// Shared types, instruction codes and tables of the stack machine execute.
// ---------------------------------------------------------------------------
`default_nettype none
package svie_pkg;
    localparam int unsigned STACK_SLOTS_DEF = 256;

    localparam logic [5:0] K_NOP = 6'd0,  K_ADD = 6'd1,  K_SUB = 6'd2,  K_MUL = 6'd3,
        K_DIV = 6'd4,  K_REM = 6'd5,  K_LADD = 6'd6, K_LSUB = 6'd7, K_LMUL = 6'd8,
        K_LDIV = 6'd9, K_LREM = 6'd10, K_AND = 6'd11, K_OR = 6'd12, K_XOR = 6'd13,
        K_LAND = 6'd14, K_LOR = 6'd15, K_LXOR = 6'd16, K_NOT = 6'd17, K_NEG = 6'd18,
        K_LNOT = 6'd19, K_LNEG = 6'd20, K_BEQ = 6'd21, K_BNE = 6'd22, K_BLT = 6'd23,
        K_BGT = 6'd24, K_BLE = 6'd25, K_BGE = 6'd26, K_ZEQ = 6'd27, K_ZNE = 6'd28,
        K_ZLT = 6'd29, K_ZGT = 6'd30, K_ZLE = 6'd31, K_ZGE = 6'd32, K_ICMP = 6'd33,
        K_LCMP = 6'd34, K_BPUSH = 6'd35, K_SPUSH = 6'd36, K_IPUSH = 6'd37,
        K_LPUSH = 6'd38, K_CM1 = 6'd39, K_C0 = 6'd40, K_C1 = 6'd41, K_LC0 = 6'd42,
        K_LC1 = 6'd43;

    localparam logic [1:0] F_NONE = 2'd0, F_UNDER = 2'd1, F_OVER = 2'd2, F_DIVZ = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_LAT, S_EXEC, S_MUL, S_DIV,
        S_FIX, S_WR0, S_WR1, S_TOP, S_OUT
    } t_state;

    // Iterative unit commands and status
    typedef struct packed {
        logic start;
        logic is_div;
        logic is_long;
    } t_ucmd;

    typedef struct packed {
        logic done;
    } t_ustat;

    function automatic logic [2:0] pop_count(input logic [5:0] k);
        logic [2:0] r;
        r = 3'd0;
        if (k >= K_ADD && k <= K_REM) r = 3'd2;
        else if (k >= K_LADD && k <= K_LREM) r = 3'd4;
        else if (k >= K_AND && k <= K_XOR) r = 3'd2;
        else if (k >= K_LAND && k <= K_LXOR) r = 3'd4;
        else if (k == K_NOT || k == K_NEG) r = 3'd1;
        else if (k == K_LNOT || k == K_LNEG) r = 3'd2;
        else if (k >= K_BEQ && k <= K_BGE) r = 3'd2;
        else if (k >= K_ZEQ && k <= K_ZGE) r = 3'd1;
        else if (k == K_ICMP) r = 3'd2;
        else if (k == K_LCMP) r = 3'd4;
        return r;
    endfunction

    function automatic logic [1:0] push_count(input logic [5:0] k);
        logic [1:0] r;
        r = 2'd0;
        if (k >= K_ADD && k <= K_REM) r = 2'd1;
        else if (k >= K_LADD && k <= K_LREM) r = 2'd2;
        else if (k >= K_AND && k <= K_NEG) r = (k >= K_LAND && k <= K_LXOR) ? 2'd2 : 2'd1;
        else if (k == K_LNOT || k == K_LNEG) r = 2'd2;
        else if (k >= K_ICMP && k <= K_IPUSH) r = 2'd1;
        else if (k == K_LPUSH) r = 2'd2;
        else if (k >= K_CM1 && k <= K_C1) r = 2'd1;
        else if (k == K_LC0 || k == K_LC1) r = 2'd2;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/stack_vm_integer_execute.sv
// Sequence: after the request is taken, up to four slot reads, a read-latency
// state, execute, then for multiply and divide the shared shift-add / restoring
// unit and a sign fix-up, up to two slot writes, a top read and the output state.
// Throughput: one request at a time; the next is taken only after the result is
// taken, and the single-port stack memory serializes the slot reads and writes.
// Reset clears stack pointer and control; stack contents stay undefined.
// ---------------------------------------------------------------------------
// stack_vm_integer_execute
// Executes one decoded integer bytecode instruction against an operand stack.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stack_vm_integer_execute_defines.svh"
module stack_vm_integer_execute #(
    parameter int unsigned STACK_SLOTS = svie_pkg::STACK_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [5:0]         i_kind,
    input  wire logic signed [63:0] i_immediate,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [63:0]      o_top_value,
    output logic                    o_branch_taken,
    output logic signed [15:0]      o_branch_offset,
    output logic [8:0]              o_depth,
    output logic [1:0]              o_fault
);
    import svie_pkg::*;

    localparam int unsigned AW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int unsigned PW = $clog2(STACK_SLOTS + 1) + 1;

    t_state r_state, n_state;
    logic [PW-1:0] r_sp, n_sp;
    logic [5:0]  r_kind;
    logic [63:0] r_imm;
    logic [2:0]  r_pops;
    logic [1:0]  r_push;
    logic [31:0] r_w0, r_w1, r_w2, r_w3;   // slots sp-1 .. sp-4
    logic [63:0] r_res, n_res;
    logic        r_taken, n_taken;
    logic [1:0]  r_fault, n_fault;
    logic        r_nsgn, r_rsgn;

    // Stack memory, one port
    logic [31:0] mem [STACK_SLOTS];
    logic [31:0] r_rd;
    logic        mem_we;
    logic [PW-1:0] mem_addr_w;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        r_rd <= mem[mem_addr];
    end
    assign mem_addr = mem_addr_w[AW-1:0];

    // Operands as seen by the execute step
    logic signed [31:0] rhs, lhs;
    logic [63:0] l_rhs, l_lhs;
    assign rhs   = r_w0;
    assign lhs   = r_w1;
    assign l_rhs = {r_w0, r_w1};
    assign l_lhs = {r_w2, r_w3};

    logic is_long_md, is_md, is_div, divz;
    assign is_md  = (r_kind == K_MUL || r_kind == K_DIV || r_kind == K_REM ||
                     r_kind == K_LMUL || r_kind == K_LDIV || r_kind == K_LREM);
    assign is_long_md = (r_kind == K_LMUL || r_kind == K_LDIV || r_kind == K_LREM);
    assign is_div = !(r_kind == K_MUL || r_kind == K_LMUL);
    assign divz = ((r_kind == K_DIV || r_kind == K_REM) && rhs == 0) ||
                  ((r_kind == K_LDIV || r_kind == K_LREM) && l_rhs == 64'd0);

    // Operand magnitudes for the iterative unit
    logic [63:0] ua, ub, sa, sb;
    logic        na, nb;
    always_comb begin
        sa = is_long_md ? l_lhs : {{32{lhs[31]}}, lhs};
        sb = is_long_md ? l_rhs : {{32{rhs[31]}}, rhs};
        na = is_div && sa[63];
        nb = is_div && sb[63];
        ua = na ? (64'd0 - sa) : sa;
        ub = nb ? (64'd0 - sb) : sb;
        if (!is_long_md && !is_div) begin
            ua = {32'd0, sa[31:0]}; ub = {32'd0, sb[31:0]};
        end
    end

    t_ucmd  ucmd;
    t_ustat ustat;
    logic [63:0] u_lo, u_hi;
    svie_muldiv u_md (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(ucmd), .i_a(ua), .i_b(ub),
        .o_stat(ustat), .o_lo(u_lo), .o_hi(u_hi)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD0;
            S_RD0:  n_state = (r_pops > 3'd1) ? S_RD1 : S_LAT;
            S_RD1:  n_state = (r_pops > 3'd2) ? S_RD2 : S_LAT;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_LAT;
            S_LAT:  n_state = S_EXEC;
            S_EXEC: begin
                if (r_fault != F_NONE || divz) n_state = S_TOP;
                else if (is_md) n_state = is_div ? S_DIV : S_MUL;
                else n_state = (r_push != 2'd0) ? S_WR0 : S_TOP;
            end
            S_MUL:  if (ustat.done) n_state = S_FIX;
            S_DIV:  if (ustat.done) n_state = S_FIX;
            S_FIX:  n_state = S_WR0;
            S_WR0:  n_state = (r_push == 2'd2) ? S_WR1 : S_TOP;
            S_WR1:  n_state = S_TOP;
            S_TOP:  n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Execute result
    logic [63:0] alu;
    logic        alu_t;
    logic        llt, lgt;
    always_comb begin
        alu = '0; alu_t = 1'b0;
        llt = $signed(l_lhs) < $signed(l_rhs);
        lgt = $signed(l_lhs) > $signed(l_rhs);
        unique case (r_kind)
            K_ADD:  alu = {32'd0, lhs + rhs};
            K_SUB:  alu = {32'd0, lhs - rhs};
            K_LADD: alu = l_lhs + l_rhs;
            K_LSUB: alu = l_lhs - l_rhs;
            K_AND:  alu = {32'd0, lhs & rhs};
            K_OR:   alu = {32'd0, lhs | rhs};
            K_XOR:  alu = {32'd0, lhs ^ rhs};
            K_LAND: alu = l_lhs & l_rhs;
            K_LOR:  alu = l_lhs | l_rhs;
            K_LXOR: alu = l_lhs ^ l_rhs;
            K_NOT:  alu = {32'd0, ~rhs};
            K_NEG:  alu = {32'd0, 32'd0 - rhs};
            K_LNOT: alu = ~l_rhs;
            K_LNEG: alu = 64'd0 - l_rhs;
            K_BEQ:  alu_t = lhs == rhs;
            K_BNE:  alu_t = lhs != rhs;
            K_BLT:  alu_t = lhs < rhs;
            K_BGT:  alu_t = lhs > rhs;
            K_BLE:  alu_t = lhs <= rhs;
            K_BGE:  alu_t = lhs >= rhs;
            K_ZEQ:  alu_t = rhs == 0;
            K_ZNE:  alu_t = rhs != 0;
            K_ZLT:  alu_t = rhs < 0;
            K_ZGT:  alu_t = rhs > 0;
            K_ZLE:  alu_t = rhs <= 0;
            K_ZGE:  alu_t = rhs >= 0;
            K_ICMP: alu = (lhs < rhs) ? '1 : ((lhs > rhs) ? 64'd1 : 64'd0);
            K_LCMP: alu = llt ? '1 : (lgt ? 64'd1 : 64'd0);
            K_BPUSH: alu = {{56{r_imm[7]}}, r_imm[7:0]};
            K_SPUSH: alu = {{48{r_imm[15]}}, r_imm[15:0]};
            K_IPUSH: alu = {32'd0, r_imm[31:0]};
            K_LPUSH: alu = r_imm;
            K_CM1:  alu = '1;
            K_C1, K_LC1: alu = 64'd1;
            default: alu = '0;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        ucmd = '0;
        mem_we = 1'b0; mem_addr_w = r_sp - PW'(1); mem_wd = r_res[31:0];
        n_res = r_res; n_taken = r_taken; n_fault = r_fault; n_sp = r_sp;
        o_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                // stack bounds are checked as the request is taken
                n_taken = 1'b0;
                if ({1'b0, r_sp} < (PW+1)'(pop_count(i_kind)))
                    n_fault = F_UNDER;
                else if ({1'b0, r_sp} - (PW+1)'(pop_count(i_kind))
                         + (PW+1)'(push_count(i_kind)) > (PW+1)'(STACK_SLOTS))
                    n_fault = F_OVER;
                else
                    n_fault = F_NONE;
            end
            S_RD0: mem_addr_w = r_sp - PW'(1);
            S_RD1: mem_addr_w = r_sp - PW'(2);
            S_RD2: mem_addr_w = r_sp - PW'(3);
            S_RD3: mem_addr_w = r_sp - PW'(4);
            S_EXEC: begin
                if (r_fault == F_NONE) begin
                    if (divz) n_fault = F_DIVZ;
                    else begin
                        n_res = alu; n_taken = alu_t;
                        ucmd.start = is_md; ucmd.is_div = is_div;
                        ucmd.is_long = is_long_md;
                        n_sp = r_sp - PW'(r_pops);
                    end
                end
            end
            S_FIX: begin
                if (!is_div) n_res = is_long_md ? u_lo : {32'd0, u_lo[31:0]};
                else if (r_kind == K_DIV || r_kind == K_LDIV)
                    n_res = r_nsgn ? 64'd0 - u_lo : u_lo;
                else
                    n_res = r_rsgn ? 64'd0 - u_hi : u_hi;
            end
            S_WR0: begin
                mem_we = 1'b1; mem_addr_w = r_sp; mem_wd = r_res[31:0];
                if (r_push == 2'd1) n_sp = r_sp + PW'(1);
            end
            S_WR1: begin
                mem_we = 1'b1; mem_addr_w = r_sp + PW'(1); mem_wd = r_res[63:32];
                n_sp = r_sp + PW'(2);
            end
            S_TOP: mem_addr_w = r_sp - PW'(1);
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sp <= '0; r_fault <= F_NONE; r_taken <= 1'b0;
        end else begin
            r_state <= n_state; r_sp <= n_sp; r_fault <= n_fault; r_taken <= n_taken;
        end
        if (r_state == S_IDLE) begin
            r_kind <= i_kind; r_imm <= i_immediate;
            r_pops <= pop_count(i_kind); r_push <= push_count(i_kind);
        end
        // read data is registered and lands in the cycle after the address
        if (r_state == S_RD1) r_w0 <= r_rd;
        if (r_state == S_RD2) r_w1 <= r_rd;
        if (r_state == S_RD3) r_w2 <= r_rd;
        if (r_state == S_LAT) begin
            if (r_pops == 3'd1) r_w0 <= r_rd;
            else if (r_pops == 3'd2) r_w1 <= r_rd;
            else r_w3 <= r_rd;
        end
        if (r_state == S_EXEC) begin
            r_nsgn <= na ^ nb;
            r_rsgn <= na;
        end
        r_res <= n_res;
    end

    // Result; the top slot read issued in S_TOP is held on the read port during S_OUT
    assign o_valid         = (r_state == S_OUT);
    assign o_top_value     = (r_sp == '0) ? 64'sd0
                           : (r_push == 2'd2 && r_fault == F_NONE) ? r_res
                           : {{32{r_rd[31]}}, r_rd};
    assign o_branch_taken  = r_taken;
    assign o_branch_offset = r_taken ? r_imm[15:0] : 16'sd0;
    assign o_depth         = 9'(r_sp);
    assign o_fault         = r_fault;

    `SVIE_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `SVIE_ASSERT_IMP(a_sp_bound, i_clk, i_rst_n, 1'b1, r_sp <= PW'(STACK_SLOTS))
    `SVIE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
endmodule
`default_nettype wire

>>> rtl/svie_muldiv.sv
// ---------------------------------------------------------------------------
// svie_muldiv
// Shared iterative unit: shift-add multiply and restoring divide, one bit a
// cycle, on magnitudes; signs are applied by the caller.
// ---------------------------------------------------------------------------
`default_nettype none
module svie_muldiv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire svie_pkg::t_ucmd    i_cmd,
    input  wire logic [63:0]        i_a,
    input  wire logic [63:0]        i_b,
    output svie_pkg::t_ustat        o_stat,
    output logic [63:0]             o_lo,
    output logic [63:0]             o_hi
);
    import svie_pkg::*;

    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_div, n_div;
    logic [63:0] r_acc, n_acc;    // product or quotient
    logic [63:0] r_rem, n_rem;    // remainder
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [64:0] trial;

    // One step of multiply or divide
    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_div = r_div;
        n_acc = r_acc; n_rem = r_rem; n_a = r_a; n_b = r_b;
        trial = {r_rem, r_a[63]} - {1'b0, r_b};
        if (i_cmd.start) begin
            n_busy = 1'b1; n_div = i_cmd.is_div;
            n_cnt  = i_cmd.is_long ? 7'd64 : 7'd32;
            // int divide shifts the dividend in from the top half
            n_a    = (i_cmd.is_long || !i_cmd.is_div) ? i_a : {i_a[31:0], 32'd0};
            n_b    = i_b; n_acc = '0; n_rem = '0;
        end else if (r_busy) begin
            if (r_div) begin
                if (!trial[64]) begin
                    n_rem = trial[63:0]; n_acc = {r_acc[62:0], 1'b1};
                end else begin
                    n_rem = {r_rem[62:0], r_a[63]}; n_acc = {r_acc[62:0], 1'b0};
                end
                n_a = {r_a[62:0], 1'b0};
            end else begin
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[62:0], 1'b0};
                n_b = {1'b0, r_b[63:1]};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    // Registers of the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_div <= n_div; r_acc <= n_acc; r_rem <= n_rem; r_a <= n_a; r_b <= n_b;
    end

    assign o_stat.done = r_busy && (r_cnt == 7'd1);
    assign o_lo = r_acc;
    assign o_hi = r_rem;
endmodule
`default_nettype wire
